// ===== design/specific_humidity_from_rel_humidity_assert.svh =====
// Assertion macros of the humidity converter RTL.
// Depends on nothing; included by the top level, which carries the assertions.
`ifndef SPECIFIC_HUMIDITY_FROM_REL_HUMIDITY_ASSERT_SVH
`define SPECIFIC_HUMIDITY_FROM_REL_HUMIDITY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SHRH_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHRH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/shrh_pkg.sv =====
// Types, widths and constants of the specific humidity converter.
// No dependencies; used by the interfaces, the exponential cell and the top level.
package shrh_pkg;

   // Field widths of the channels.
   localparam int TEMP_W      = 15;
   localparam int PRESS_W     = 18;
   localparam int RH_W        = 17;
   localparam int SPEC_W      = 16;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 17;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_METHOD_SELECT     = 4'd0,
      CSR_RELATIVE_HUMIDITY = 4'd1
   } csr_index_type;

   // Input clamps.
   localparam logic [TEMP_W-1:0] T_LOW  = 15'd12800;
   localparam logic [RH_W-1:0]   RH_ONE = 17'd65536;

   // Exponent of the saturation formulas, Celsius in units of 1/640 degree.
   localparam logic signed [19:0] U_OFFSET     = 20'sd174816;
   localparam logic [26:0]        MAGNUS_COEF  = 27'd1762;
   localparam logic signed [25:0] MAGNUS_DEN0  = 26'sd15559680;
   localparam logic signed [27:0] BUCK_LEAD0   = 28'sd70079856;
   localparam logic signed [25:0] BUCK_DEN0    = 26'sd1645696;
   localparam logic [18:0]        BUCK_SCALE   = 19'd375200;

   // Exponent divider shape.
   localparam int EXP_NUM_W = 65;
   localparam int EXP_DEN_W = 41;
   localparam int EXP_QUO_W = 25;

   // Base-2 exponential.
   localparam int ACC_W   = 31;
   localparam int Z_W     = 30;
   localparam int SHIFT_W = 6;
   localparam int HORNER_TERMS = 10;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [ACC_W-1:0] ONE_Q30 = 31'd1 << 30;
   localparam logic [36:0] YB_BIAS   = 37'd1 << 35;
   localparam logic [6:0]  SHIFT_BASE = 7'd70;

   // Prefactors in hundredths of a pascal.
   localparam logic [15:0] PREF_BUCK   = 16'd61121;
   localparam logic [15:0] PREF_MAGNUS = 16'd61120;

   // Partial pressure, Q8 pascals, and the divide by one hundred.
   localparam int PW_W = 26;
   localparam logic [39:0] PW_BIG      = 40'd100 << 26;
   localparam logic [30:0] RECIP25_Q35 = 31'd1374389534;
   localparam logic [30:0] DIV25       = 31'd25;

   // Gas constants, milli units.
   localparam logic [18:0] R_DRY   = 19'd287058;
   localparam logic [18:0] R_WATER = 19'd461510;

   // Final ratio divider shape.
   localparam int Q_NUM_W = 62;
   localparam int Q_DEN_W = 46;
   localparam int Q_QUO_W = 17;
   localparam logic [SPEC_W-1:0] SPEC_MAX = 16'hFFFF;

   // Data that travels beside the exponent divider.
   typedef struct packed {
      logic              neg;
      logic              magnus;
      logic [RH_W-1:0]   rh;
      logic [PRESS_W-1:0] press;
   } exp_side_type;

   // Data that travels beside the exponential cells.
   typedef struct packed {
      logic [SHIFT_W-1:0] shift;
      logic               magnus;
      logic [RH_W-1:0]    rh;
      logic [PRESS_W-1:0] press;
   } pow_side_type;

endpackage

// ===== design/shrh_req_if.sv =====
// Channel interfaces of the humidity converter: samples, results, registers.
// Depends on shrh_pkg for the field widths.
interface shrh_req_if import shrh_pkg::*;;
   logic                valid;
   logic                ready;
   logic [TEMP_W-1:0]   temperature_kelvin;
   logic [PRESS_W-1:0]  pressure_pa;
   modport source (output valid, temperature_kelvin, pressure_pa, input ready);
   modport sink (input valid, temperature_kelvin, pressure_pa, output ready);
endinterface

interface shrh_rsp_if import shrh_pkg::*;;
   logic               valid;
   logic               ready;
   logic [SPEC_W-1:0]  specific_humidity;
   logic               out_of_range;
   modport source (output valid, specific_humidity, out_of_range, input ready);
   modport sink (input valid, specific_humidity, out_of_range, output ready);
endinterface

interface shrh_csr_if import shrh_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/specific_humidity_from_rel_humidity.sv =====
// Top level of the specific humidity converter: channels, pipeline, output skid.
// Depends on shrh_pkg, the channel interfaces, shrh_div_cell, shrh_exp_cell
// and the assertion macro header.
//
// Takes one temperature and pressure beat per cycle and returns one specific
// humidity beat for each, in order. The work is a fixed pipeline: a 25-cell
// divider for the Buck or Magnus exponent, ten three-stage Horner cells for the
// base-2 exponential, a chain of single multiplies for the partial pressure,
// and a 17-cell divider for the final ratio. A full output register plus a
// one-beat skid let the pipeline keep taking beats while a result waits;
// req_bus.ready drops only when the skid is occupied. Register writes are
// always accepted and take effect for beats accepted afterwards.
`include "specific_humidity_from_rel_humidity_assert.svh"

module specific_humidity_from_rel_humidity import shrh_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   shrh_req_if.sink   req_bus,
   shrh_rsp_if.source rsp_bus,
   shrh_csr_if.sink   csr_bus
);

   localparam int EXP_SIDE_W = $bits(exp_side_type);
   localparam int POW_SIDE_W = $bits(pow_side_type);

   // Configuration registers.
   logic            method_ff;
   logic [RH_W-1:0] rh_ff;

   // Pipeline advance.
   logic en;

   // Stage valids.
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic e_valid_ff, f_valid_ff, g_valid_ff;
   logic h_valid_ff, i_valid_ff, j_valid_ff, k_valid_ff, l_valid_ff;
   logic m_valid_ff, n_valid_ff, o_valid_ff, p_valid_ff, s_valid_ff;

   // Capture stage.
   logic [TEMP_W-1:0]  a_temp_ff, a_temp_in;
   logic [RH_W-1:0]    a_rh_ff, a_rh_in;
   logic               a_magnus_ff;
   logic [PRESS_W-1:0] a_press_ff;

   // Exponent operands.
   logic [18:0]        b_temp10;
   logic signed [19:0] b_u;
   logic signed [27:0] b_lead_s;
   logic signed [25:0] b_dbase_s;
   logic [17:0]        b_mag_ff, b_mag_in;
   logic [26:0]        b_lead_ff, b_lead_in;
   logic [24:0]        b_dbase_ff, b_dbase_in;
   exp_side_type       b_side_ff, b_side_in;

   logic [44:0]          c_num_ff, c_num_in;
   logic [EXP_DEN_W-1:0] c_den_ff, c_den_in;
   exp_side_type         c_side_ff;

   logic [EXP_NUM_W-1:0] d_num_ff, d_num_in;
   logic [EXP_DEN_W-1:0] d_den_ff;
   exp_side_type         d_side_ff;

   // Exponent divider chain.
   logic                 ediv_valid [0:EXP_QUO_W];
   logic [EXP_NUM_W-1:0] ediv_rem   [0:EXP_QUO_W];
   logic [EXP_DEN_W-1:0] ediv_den   [0:EXP_QUO_W];
   logic [EXP_QUO_W-1:0] ediv_quo   [0:EXP_QUO_W];
   exp_side_type         ediv_side  [0:EXP_QUO_W];

   // Base-2 split.
   logic [56:0]   e_prod;
   logic [35:0]   e_ym_ff, e_ym_in;
   exp_side_type  e_side_ff;
   logic [36:0]   f_yb_ff, f_yb_in;
   exp_side_type  f_side_ff;
   logic [59:0]   g_prod;
   logic [Z_W-1:0] g_z_ff, g_z_in;
   pow_side_type  g_side_ff, g_side_in;

   // Horner chain.
   logic             pow_valid [0:HORNER_TERMS];
   logic [ACC_W-1:0] pow_acc   [0:HORNER_TERMS];
   logic [Z_W-1:0]   pow_z     [0:HORNER_TERMS];
   pow_side_type     pow_side  [0:HORNER_TERMS];

   // Partial pressure.
   logic [15:0]      h_pref;
   logic [46:0]      h_pa_ff, h_pa_in;
   pow_side_type     h_side_ff;
   logic [63:0]      i_prod_ff, i_prod_in;
   pow_side_type     i_side_ff;
   logic [64:0]      j_sum_ff, j_sum_in;
   pow_side_type     j_side_ff;
   logic [39:0]      k_w_ff, k_w_in;
   logic [PRESS_W-1:0] k_press_ff;
   logic [61:0]      l_prod;
   logic             l_big_ff, l_big_in;
   logic [30:0]      l_w4_ff, l_w4_in;
   logic [PW_W-1:0]  l_q0_ff, l_q0_in;
   logic [PRESS_W-1:0] l_press_ff;
   logic [30:0]      m_rem;
   logic [PW_W-1:0]  m_pw_ff, m_pw_in;
   logic [PRESS_W-1:0] m_press_ff;

   // Ratio operands.
   logic [PW_W-1:0]  n_p8;
   logic             n_sat_ff, n_sat_in;
   logic [PW_W-1:0]  n_pw_ff, n_diff_ff, n_diff_in;
   logic [44:0]      o_a_ff, o_a_in, o_b_ff, o_b_in;
   logic             o_sat_ff;
   logic [Q_DEN_W-1:0] p_den_ff, p_den_in;
   logic [44:0]      p_a_ff;
   logic             p_sat_ff;
   logic [Q_NUM_W-1:0] s_num_ff, s_num_in;
   logic [Q_DEN_W-1:0] s_den_ff;
   logic             s_sat_ff;

   // Ratio divider chain.
   logic               fdiv_valid [0:Q_QUO_W];
   logic [Q_NUM_W-1:0] fdiv_rem   [0:Q_QUO_W];
   logic [Q_DEN_W-1:0] fdiv_den   [0:Q_QUO_W];
   logic [Q_QUO_W-1:0] fdiv_quo   [0:Q_QUO_W];
   logic [0:0]         fdiv_side  [0:Q_QUO_W];

   // Result and output skid.
   logic              last_valid;
   logic [SPEC_W-1:0] last_spec;
   logic              last_oor;
   logic              out_valid_ff, skid_valid_ff;
   logic [SPEC_W-1:0] out_spec_ff, skid_spec_ff;
   logic              out_oor_ff, skid_oor_ff;

   // ---------------------------------------------------------------------
   // Register port: every write beat is taken; unknown indexes are dropped.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= 1'b0;
         rh_ff     <= '0;
      end else if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_METHOD_SELECT:     method_ff <= csr_bus.data[0];
            CSR_RELATIVE_HUMIDITY: rh_ff     <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the skid has room.
   assign en            = !skid_valid_ff;
   assign req_bus.ready = en;

   // ---------------------------------------------------------------------
   // Valid bits of the top-level stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0; b_valid_ff <= 1'b0; c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0; e_valid_ff <= 1'b0; f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0; h_valid_ff <= 1'b0; i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0; k_valid_ff <= 1'b0; l_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0; n_valid_ff <= 1'b0; o_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0; s_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_bus.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= ediv_valid[EXP_QUO_W];
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= pow_valid[HORNER_TERMS];
         i_valid_ff <= h_valid_ff;
         j_valid_ff <= i_valid_ff;
         k_valid_ff <= j_valid_ff;
         l_valid_ff <= k_valid_ff;
         m_valid_ff <= l_valid_ff;
         n_valid_ff <= m_valid_ff;
         o_valid_ff <= n_valid_ff;
         p_valid_ff <= o_valid_ff;
         s_valid_ff <= p_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Capture with the cold clamp and the humidity clamp.
   always_comb begin
      a_temp_in = (req_bus.temperature_kelvin < T_LOW) ? T_LOW
                                                       : req_bus.temperature_kelvin;
      a_rh_in   = (rh_ff > RH_ONE) ? RH_ONE : rh_ff;
   end

   // Celsius offset, magnitude, and the numerator and denominator bases.
   always_comb begin
      b_temp10  = 19'(a_temp_ff) * 19'd10;
      b_u       = $signed({1'b0, b_temp10}) - U_OFFSET;
      b_mag_in  = b_u[19] ? 18'(-b_u) : 18'(b_u);
      b_lead_s  = BUCK_LEAD0 - 28'(b_u) * 28'sd25;
      b_dbase_s = a_magnus_ff ? (MAGNUS_DEN0 + 26'(b_u) * 26'sd100)
                              : (BUCK_DEN0 + 26'(b_u) * 26'sd10);
      b_lead_in  = a_magnus_ff ? MAGNUS_COEF : b_lead_s[26:0];
      b_dbase_in = b_dbase_s[24:0];
      b_side_in.neg    = b_u[19];
      b_side_in.magnus = a_magnus_ff;
      b_side_in.rh     = a_rh_ff;
      b_side_in.press  = a_press_ff;
   end

   // Numerator product and scaled Buck denominator.
   always_comb begin
      c_num_in = 45'(b_lead_ff) * 45'(b_mag_ff);
      c_den_in = b_side_ff.magnus ? EXP_DEN_W'(b_dbase_ff)
                                  : EXP_DEN_W'(b_dbase_ff) * EXP_DEN_W'(BUCK_SCALE);
   end

   // Q20 numerator with the rounding half of the divisor.
   assign d_num_in = EXP_NUM_W'({c_num_ff, 20'd0}) + EXP_NUM_W'(c_den_ff >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         a_temp_ff   <= a_temp_in;
         a_rh_ff     <= a_rh_in;
         a_magnus_ff <= method_ff;
         a_press_ff  <= req_bus.pressure_pa;
         b_mag_ff    <= b_mag_in;
         b_lead_ff   <= b_lead_in;
         b_dbase_ff  <= b_dbase_in;
         b_side_ff   <= b_side_in;
         c_num_ff    <= c_num_in;
         c_den_ff    <= c_den_in;
         c_side_ff   <= b_side_ff;
         d_num_ff    <= d_num_in;
         d_den_ff    <= c_den_ff;
         d_side_ff   <= c_side_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Exponent divider, one quotient bit per cell, most significant first.
   assign ediv_valid[0] = d_valid_ff;
   assign ediv_rem[0]   = d_num_ff;
   assign ediv_den[0]   = d_den_ff;
   assign ediv_quo[0]   = '0;
   assign ediv_side[0]  = d_side_ff;

   for (genvar gi = 0; gi < EXP_QUO_W; gi++) begin : g_ediv
      shrh_div_cell #(
         .NUM_W  (EXP_NUM_W),
         .DEN_W  (EXP_DEN_W),
         .QUO_W  (EXP_QUO_W),
         .BIT    (EXP_QUO_W - 1 - gi),
         .SIDE_W (EXP_SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (ediv_valid[gi]),
         .in_rem    (ediv_rem[gi]),
         .in_den    (ediv_den[gi]),
         .in_quo    (ediv_quo[gi]),
         .in_side   (ediv_side[gi]),
         .out_valid (ediv_valid[gi+1]),
         .out_rem   (ediv_rem[gi+1]),
         .out_den   (ediv_den[gi+1]),
         .out_quo   (ediv_quo[gi+1]),
         .out_side  (ediv_side[gi+1])
      );
   end

   // ---------------------------------------------------------------------
   // Scale to base two, split integer and fraction, fraction times ln 2.
   always_comb begin
      e_prod  = 57'(ediv_quo[EXP_QUO_W]) * 57'(LOG2E_Q30) + (57'd1 << 19);
      e_ym_in = e_prod[55:20];
      f_yb_in = (e_side_ff.neg ? (37'd0 - 37'(e_ym_ff)) : 37'(e_ym_ff)) + YB_BIAS;
      g_prod  = 60'(f_yb_ff[29:0]) * 60'(LN2_Q30);
      g_z_in  = g_prod[59:30];
      g_side_in.shift  = SHIFT_W'(SHIFT_BASE - f_yb_ff[36:30]);
      g_side_in.magnus = f_side_ff.magnus;
      g_side_in.rh     = f_side_ff.rh;
      g_side_in.press  = f_side_ff.press;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ym_ff   <= e_ym_in;
         e_side_ff <= ediv_side[EXP_QUO_W];
         f_yb_ff   <= f_yb_in;
         f_side_ff <= e_side_ff;
         g_z_ff    <= g_z_in;
         g_side_ff <= g_side_in;
      end
   end

   // ---------------------------------------------------------------------
   // Horner chain for 2^f, divisors from ten down to one.
   assign pow_valid[0] = g_valid_ff;
   assign pow_acc[0]   = ONE_Q30;
   assign pow_z[0]     = g_z_ff;
   assign pow_side[0]  = g_side_ff;

   for (genvar gk = 0; gk < HORNER_TERMS; gk++) begin : g_pow
      shrh_exp_cell #(
         .K      (HORNER_TERMS - gk),
         .SIDE_W (POW_SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (pow_valid[gk]),
         .in_acc    (pow_acc[gk]),
         .in_z      (pow_z[gk]),
         .in_side   (pow_side[gk]),
         .out_valid (pow_valid[gk+1]),
         .out_acc   (pow_acc[gk+1]),
         .out_z     (pow_z[gk+1]),
         .out_side  (pow_side[gk+1])
      );
   end

   // ---------------------------------------------------------------------
   // Partial pressure: prefactor, humidity, rounding shift, divide by 100.
   always_comb begin
      h_pref    = pow_side[HORNER_TERMS].magnus ? PREF_MAGNUS : PREF_BUCK;
      h_pa_in   = 47'(h_pref) * 47'(pow_acc[HORNER_TERMS]);
      i_prod_in = 64'(h_pa_ff) * 64'(h_side_ff.rh);
      j_sum_in  = 65'(i_prod_ff) + (65'd50 << i_side_ff.shift);
      k_w_in    = 40'(j_sum_ff >> j_side_ff.shift);
   end

   // A value at or above 100 * 2^26 is far beyond any total pressure.
   always_comb begin
      l_big_in = (k_w_ff >= PW_BIG);
      l_w4_in  = k_w_ff[32:2];
      l_prod   = 62'(l_w4_in) * 62'(RECIP25_Q35);
      l_q0_in  = l_prod[60:35];
   end

   // One correction step of the reciprocal estimate.
   always_comb begin
      m_rem   = l_w4_ff - 31'(l_q0_ff) * DIV25;
      m_pw_in = l_big_ff ? {PW_W{1'b1}} : (l_q0_ff + PW_W'(m_rem >= DIV25));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_pa_ff    <= h_pa_in;
         h_side_ff  <= pow_side[HORNER_TERMS];
         i_prod_ff  <= i_prod_in;
         i_side_ff  <= h_side_ff;
         j_sum_ff   <= j_sum_in;
         j_side_ff  <= i_side_ff;
         k_w_ff     <= k_w_in;
         k_press_ff <= j_side_ff.press;
         l_big_ff   <= l_big_in;
         l_w4_ff    <= l_w4_in;
         l_q0_ff    <= l_q0_in;
         l_press_ff <= k_press_ff;
         m_pw_ff    <= m_pw_in;
         m_press_ff <= l_press_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Saturation test and the dry and water terms of the ratio.
   always_comb begin
      n_p8      = {m_press_ff, 8'd0};
      n_sat_in  = (m_pw_ff >= n_p8);
      n_diff_in = n_p8 - m_pw_ff;
      o_a_in    = 45'(n_pw_ff) * 45'(R_DRY);
      o_b_in    = 45'(n_diff_ff) * 45'(R_WATER);
      p_den_in  = Q_DEN_W'(o_a_ff) + Q_DEN_W'(o_b_ff);
      s_num_in  = Q_NUM_W'({p_a_ff, 16'd0}) + Q_NUM_W'(p_den_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_sat_ff  <= n_sat_in;
         n_pw_ff   <= m_pw_ff;
         n_diff_ff <= n_diff_in;
         o_a_ff    <= o_a_in;
         o_b_ff    <= o_b_in;
         o_sat_ff  <= n_sat_ff;
         p_den_ff  <= p_den_in;
         p_a_ff    <= o_a_ff;
         p_sat_ff  <= o_sat_ff;
         s_num_ff  <= s_num_in;
         s_den_ff  <= p_den_ff;
         s_sat_ff  <= p_sat_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Ratio divider, 17 quotient bits.
   assign fdiv_valid[0] = s_valid_ff;
   assign fdiv_rem[0]   = s_num_ff;
   assign fdiv_den[0]   = s_den_ff;
   assign fdiv_quo[0]   = '0;
   assign fdiv_side[0]  = s_sat_ff;

   for (genvar gq = 0; gq < Q_QUO_W; gq++) begin : g_fdiv
      shrh_div_cell #(
         .NUM_W  (Q_NUM_W),
         .DEN_W  (Q_DEN_W),
         .QUO_W  (Q_QUO_W),
         .BIT    (Q_QUO_W - 1 - gq),
         .SIDE_W (1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (fdiv_valid[gq]),
         .in_rem    (fdiv_rem[gq]),
         .in_den    (fdiv_den[gq]),
         .in_quo    (fdiv_quo[gq]),
         .in_side   (fdiv_side[gq]),
         .out_valid (fdiv_valid[gq+1]),
         .out_rem   (fdiv_rem[gq+1]),
         .out_den   (fdiv_den[gq+1]),
         .out_quo   (fdiv_quo[gq+1]),
         .out_side  (fdiv_side[gq+1])
      );
   end

   // Saturated or rounded-to-one results clip to the largest code.
   always_comb begin
      last_valid = fdiv_valid[Q_QUO_W];
      last_oor   = fdiv_side[Q_QUO_W][0];
      last_spec  = (last_oor || fdiv_quo[Q_QUO_W][Q_QUO_W-1]) ? SPEC_MAX
                                                              : fdiv_quo[Q_QUO_W][SPEC_W-1:0];
   end

   // ---------------------------------------------------------------------
   // Output register with a one-beat skid behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_bus.ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (last_valid) begin
         if (!out_valid_ff || rsp_bus.ready) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_bus.ready) begin
            out_spec_ff <= skid_spec_ff;
            out_oor_ff  <= skid_oor_ff;
         end
      end else if (last_valid) begin
         if (!out_valid_ff || rsp_bus.ready) begin
            out_spec_ff <= last_spec;
            out_oor_ff  <= last_oor;
         end else begin
            skid_spec_ff <= last_spec;
            skid_oor_ff  <= last_oor;
         end
      end
   end

   assign rsp_bus.valid             = out_valid_ff;
   assign rsp_bus.specific_humidity = out_spec_ff;
   assign rsp_bus.out_of_range      = out_oor_ff;

   // ---------------------------------------------------------------------
   // Checks on the output buffering and the saturation code.
   `SHRH_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid holds a beat while the output register is empty")
   `SHRH_ASSERT_NEXT(a_stall_fills_skid, clock, reset, (!skid_valid_ff && last_valid && out_valid_ff && !rsp_bus.ready), skid_valid_ff, "stalled result was not parked in the skid")
   `SHRH_ASSERT_IMPLIES(a_flag_saturates, clock, reset, (out_valid_ff && out_oor_ff), (out_spec_ff == SPEC_MAX), "out of range result is not saturated")

endmodule

// ===== design/shrh_div_cell.sv =====
// One bit of a pipelined restoring divider: trial subtract and register.
// Depends on nothing but its parameters; chained by the top level.
module shrh_div_cell #(
   parameter int NUM_W  = 65,
   parameter int DEN_W  = 41,
   parameter int QUO_W  = 25,
   parameter int BIT    = 0,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_rem,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [QUO_W-1:0]  in_quo,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_rem,
   output logic [DEN_W-1:0]  out_den,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [SIDE_W-1:0] side_ff;
   logic [NUM_W-1:0]  trial;
   logic              fits;

   // Divisor aligned to this quotient bit; subtract when it fits.
   always_comb begin
      trial  = NUM_W'(in_den) << BIT;
      fits   = (in_rem >= trial);
      rem_in = fits ? (in_rem - trial) : in_rem;
      quo_in = in_quo;
      quo_in[BIT] = fits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         quo_ff  <= quo_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;

endmodule

// ===== design/shrh_exp_cell.sv =====
// One Horner step of the base-2 exponential: acc = 1 + (acc * z) / K.
// Depends on shrh_pkg; ten of these are chained by the top level.
module shrh_exp_cell import shrh_pkg::*; #(
   parameter int K      = 1,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [ACC_W-1:0]  in_acc,
   input  logic [Z_W-1:0]    in_z,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [ACC_W-1:0]  out_acc,
   output logic [Z_W-1:0]    out_z,
   output logic [SIDE_W-1:0] out_side
);

   // Reciprocal of K in Q34; the estimate is low by at most one.
   localparam logic [34:0] RECIP = 35'((36'd1 << 34) / K);
   localparam logic [ACC_W-1:0] K_VAL = ACC_W'(K);

   logic [2:0]        valid_ff;
   logic [ACC_W-1:0]  p1_ff, p1_in;
   logic [Z_W-1:0]    z1_ff, z2_ff, z3_ff;
   logic [SIDE_W-1:0] side1_ff, side2_ff, side3_ff;
   logic [ACC_W-1:0]  p2_ff, q2_ff, q2_in;
   logic [ACC_W-1:0]  acc3_ff, acc3_in;
   logic [60:0]       prod1;
   logic [65:0]       prod2;
   logic [ACC_W-1:0]  rem3;

   // Product with z, back to Q30.
   always_comb begin
      prod1 = 61'(in_acc) * 61'(in_z);
      p1_in = prod1[60:30];
   end

   // Quotient estimate by the reciprocal.
   always_comb begin
      prod2 = 66'(p1_ff) * 66'(RECIP);
      q2_in = prod2[64:34];
   end

   // Correct the estimate once and add one.
   always_comb begin
      rem3    = p2_ff - ACC_W'(q2_ff * K_VAL);
      acc3_in = ONE_Q30 + q2_ff + ACC_W'(rem3 >= K_VAL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff    <= p1_in;
         z1_ff    <= in_z;
         side1_ff <= in_side;
         p2_ff    <= p1_ff;
         q2_ff    <= q2_in;
         z2_ff    <= z1_ff;
         side2_ff <= side1_ff;
         acc3_ff  <= acc3_in;
         z3_ff    <= z2_ff;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_acc   = acc3_ff;
   assign out_z     = z3_ff;
   assign out_side  = side3_ff;

endmodule

// ===== verif/tb_specific_humidity_from_rel_humidity.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the specific humidity converter: directed and random
// temperature and pressure beats under several register settings, checked in order.
// Depends on shrh_pkg, the channel interfaces and the converter RTL.
module tb_specific_humidity_from_rel_humidity;
   import shrh_pkg::*;

   typedef logic [127:0] wide_type;

   typedef struct {
      logic [TEMP_W-1:0]  temp;
      logic [PRESS_W-1:0] press;
   } sample_type;

   typedef struct {
      logic [SPEC_W-1:0] spec;
      logic              oor;
   } humidity_type;

   typedef struct {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } reg_write_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 4'd9;
   localparam int PIPE_DELAY = 90;
   localparam int STALL_LIMIT = 5000;
   localparam int LONG_HOLD = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   shrh_req_if req ();
   shrh_rsp_if rsp ();
   shrh_csr_if csr ();

   specific_humidity_from_rel_humidity dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp),
      .csr_bus (csr)
   );

   always #4 clock = ~clock;

   sample_type    sample_queue[$];
   humidity_type  humidity_expect[$];
   reg_write_type reg_queue[$];

   logic              cfg_magnus = 1'b0;
   logic [RH_W-1:0]   cfg_rh = '0;
   int                sample_beats = 0;
   int                mismatches = 0;
   bit                failed = 1'b0;

   // Predicts one result from a sample and the current register values.
   function automatic humidity_type predict_humidity(logic [TEMP_W-1:0] temp_in,
                                                     logic [PRESS_W-1:0] press_in,
                                                     logic magnus, logic [RH_W-1:0] rh_in);
      humidity_type res;
      longint    u, x, y, yb;
      int        n;
      wide_type  mag, num, den, r, xm, ym, frac, z, acc, pref, prod, d, pw, p8, a, b, q;
      logic [TEMP_W-1:0] t;
      logic [RH_W-1:0]   rh;
      t = (temp_in < T_LOW) ? T_LOW : temp_in;
      rh = (rh_in > RH_ONE) ? RH_ONE : rh_in;
      // Exponent of the saturation formula in Q20, sign kept apart.
      u = 10 * longint'(t) - 174816;
      mag = (u < 0) ? wide_type'(-u) : wide_type'(u);
      if (magnus) begin
         den = wide_type'(15559680 + 100 * u);
         num = (wide_type'(1762) * mag) << 20;
      end else begin
         den = wide_type'(375200) * wide_type'(1645696 + 10 * u);
         num = (wide_type'(70079856 - 25 * u) * mag) << 20;
      end
      r = (num + den / 2) / den;
      x = (u < 0) ? -longint'(r) : longint'(r);
      // Base-2 split: integer part and fraction in Q30.
      xm = (x < 0) ? wide_type'(-x) : wide_type'(x);
      ym = (xm * wide_type'(LOG2E_Q30) + (wide_type'(1) << 19)) >> 20;
      y = (x < 0) ? -longint'(ym) : longint'(ym);
      yb = y + (longint'(32) << 30);
      n = int'(yb >>> 30) - 32;
      frac = wide_type'(yb) & ((wide_type'(1) << 30) - 1);
      z = (frac * wide_type'(LN2_Q30)) >> 30;
      acc = wide_type'(1) << 30;
      for (int k = 10; k >= 1; k--)
         acc = (wide_type'(1) << 30) + ((acc * z) >> 30) / wide_type'(k);
      // Partial pressure of water in Q8 pascals.
      pref = magnus ? wide_type'(61120) : wide_type'(61121);
      prod = pref * acc * wide_type'(rh);
      d = wide_type'(100) << (38 - n);
      pw = (prod + d / 2) / d;
      p8 = wide_type'(press_in) << 8;
      if (pw >= p8) begin
         res.spec = SPEC_MAX;
         res.oor = 1'b1;
      end else begin
         a = pw * wide_type'(R_DRY);
         b = (p8 - pw) * wide_type'(R_WATER);
         q = ((a << 16) + (a + b) / 2) / (a + b);
         res.spec = (q > wide_type'(SPEC_MAX)) ? SPEC_MAX : q[SPEC_W-1:0];
         res.oor = 1'b0;
      end
      return res;
   endfunction

   // Sample driver: bursts of random length with random gaps between them.
   always @(posedge clock) begin : sample_driver
      int         gap;
      int         burst;
      sample_type s;
      if (reset) begin
         req.valid <= 1'b0;
         gap = 0;
         burst = 0;
      end else begin
         if (req.valid && req.ready) begin
            humidity_expect.push_back(predict_humidity(req.temperature_kelvin,
                                                       req.pressure_pa, cfg_magnus, cfg_rh));
            sample_beats <= sample_beats + 1;
         end
         if (!req.valid || req.ready) begin
            if (gap > 0) begin
               gap--;
               req.valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
               s = sample_queue.pop_front();
               req.valid <= 1'b1;
               req.temperature_kelvin <= s.temp;
               req.pressure_pa <= s.press;
               if (burst == 0) burst = $urandom_range(1, 40);
               burst--;
               if (burst == 0) gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Register write driver; the shadow copy follows each accepted beat.
   always @(posedge clock) begin : reg_driver
      reg_write_type w;
      if (reset) begin
         csr.valid <= 1'b0;
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_METHOD_SELECT) cfg_magnus <= csr.data[0];
            else if (csr.index == CSR_RELATIVE_HUMIDITY) cfg_rh <= csr.data[RH_W-1:0];
         end
         if (!csr.valid || csr.ready) begin
            if (reg_queue.size() > 0) begin
               w = reg_queue.pop_front();
               csr.valid <= 1'b1;
               csr.index <= w.index;
               csr.data <= w.data;
            end else begin
               csr.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern that switches between modes, plus one long hold.
   always @(posedge clock) begin : result_receiver
      int  cycle_cnt;
      int  hold_cnt;
      int  stall_mode;
      bit  hold_done;
      if (reset) begin
         rsp.ready <= 1'b0;
         cycle_cnt = 0;
         hold_cnt = 0;
         stall_mode = 0;
         hold_done = 1'b0;
      end else begin
         cycle_cnt++;
         if (cycle_cnt % 64 == 0) stall_mode = $urandom_range(0, 2);
         if (!hold_done && sample_beats >= 300) begin
            hold_done = 1'b1;
            hold_cnt = LONG_HOLD;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp.ready <= 1'b0;
         end else if (stall_mode == 0) begin
            rsp.ready <= 1'b1;
         end else if (stall_mode == 1) begin
            rsp.ready <= ($urandom_range(0, 3) != 0);
         end else begin
            rsp.ready <= ($urandom_range(0, 1) != 0);
         end
      end
   end

   // Result checker: each beat against the oldest prediction.
   always @(posedge clock) begin : result_checker
      humidity_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (humidity_expect.size() == 0) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: spec=%0d oor=%0d",
                        rsp.specific_humidity, rsp.out_of_range);
         end else begin
            e = humidity_expect.pop_front();
            if (rsp.specific_humidity !== e.spec || rsp.out_of_range !== e.oor) begin
               failed = 1'b1;
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected spec=%0d oor=%0d, got spec=%0d oor=%0d",
                           e.spec, e.oor, rsp.specific_humidity, rsp.out_of_range);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("** specific_humidity_from_rel_humidity: FAILED **");
            $finish;
         end
      end
   end

   task automatic add_sample(int temp, int press);
      sample_type s;
      s.temp = TEMP_W'(temp);
      s.press = PRESS_W'(press);
      sample_queue.push_back(s);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, int data);
      reg_write_type w;
      w.index = index;
      w.data = CSR_DATA_W'(data);
      reg_queue.push_back(w);
   endtask

   // Waits until all beats are out and the pipeline has drained.
   task automatic wait_drained();
      @(negedge clock);
      while (sample_queue.size() != 0 || req.valid || humidity_expect.size() != 0
             || reg_queue.size() != 0 || csr.valid)
         @(negedge clock);
      repeat (PIPE_DELAY + 10) @(negedge clock);
   endtask

   task automatic set_config(logic magnus, int rh);
      wait_drained();
      write_reg(CSR_METHOD_SELECT, magnus);
      write_reg(CSR_RELATIVE_HUMIDITY, rh);
      wait_drained();
   endtask

   // Random samples: mostly plausible weather, some full-range noise.
   task automatic add_random(int count);
      int temp, press;
      repeat (count) begin
         case ($urandom_range(0, 3))
            0: begin
               temp = $urandom_range(0, 32767);
               press = $urandom_range(0, 262143);
            end
            1: begin
               temp = $urandom_range(16000, 22000);
               press = $urandom_range(0, 8000);
            end
            default: begin
               temp = $urandom_range(15000, 21000);
               press = $urandom_range(50000, 120000);
            end
         endcase
         add_sample(temp, press);
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.temperature_kelvin = '0;
      req.pressure_pa = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset values: Buck with zero humidity.
      add_sample(17482, 101325);
      add_sample(0, 0);
      wait_drained();

      // Buck, saturated air; extremes of temperature and pressure.
      set_config(1'b0, RH_ONE);
      add_sample(0, 101325);
      add_sample(12799, 101325);
      add_sample(12800, 1);
      add_sample(32767, 262143);
      add_sample(17482, 101325);
      add_sample(19200, 0);
      add_sample(18000, 262143);
      add_sample(25000, 50000);
      add_sample(20000, 1);

      // Magnus with humidity above one, plus an ignored register index.
      wait_drained();
      write_reg(CSR_UNUSED, 17'h1ABCD);
      set_config(1'b1, 17'h1FFFF);
      add_sample(0, 262143);
      add_sample(12800, 101325);
      add_sample(32767, 262143);
      add_sample(17482, 611);
      add_sample(17482, 612);
      add_sample(21000, 7000);
      add_sample(18500, 0);

      // Random phases over several settings.
      set_config(1'b1, 32768);
      add_random(150);
      set_config(1'b0, 1);
      add_random(100);
      set_config(1'b0, $urandom_range(0, 65536));
      add_random(150);
      set_config(1'b1, 65535);
      add_random(150);
      set_config(1'b0, 65536);
      add_random(150);
      wait_drained();

      if (humidity_expect.size() != 0) failed = 1'b1;
      if (!failed) begin
         $display("** specific_humidity_from_rel_humidity: PASSED **");
      end else begin
         $display("** specific_humidity_from_rel_humidity: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/shrh_pkg.sv
design/shrh_req_if.sv
design/shrh_div_cell.sv
design/shrh_exp_cell.sv
design/specific_humidity_from_rel_humidity.sv
verif/tb_specific_humidity_from_rel_humidity.sv
